// ===== hw/rtl/ebs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ebs_pkg;

    // Number of pin lanes per field in one panel sample.
    localparam int LANES = 4;

    // Default channel counts for the top level.
    localparam int NUM_ENCODERS_DEFAULT = 4;
    localparam int NUM_BUTTONS_DEFAULT  = 4;

    // Reset values of the position counters and the debounce register.
    localparam logic [7:0] POSITION_START = 8'd128;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd3;

    // Quadrature step per {old phase, new phase}, as an 8-bit two's complement delta.
    // Phase holds A in bit 1 and B in bit 0; double transitions give no step.
    localparam logic [7:0] STEP_TABLE [0:15] = '{
        8'h00, 8'h01, 8'hFF, 8'h00,
        8'hFF, 8'h00, 8'h00, 8'h01,
        8'h01, 8'h00, 8'h00, 8'hFF,
        8'h00, 8'hFF, 8'h01, 8'h00
    };

    // One panel sample.
    typedef struct packed {
        logic [3:0] enc_a_lines;
        logic [3:0] enc_b_lines;
        logic [3:0] enc_switch_lines;
        logic [3:0] button_lines;
    } ebs_in_t;

    // One scan result.
    typedef struct packed {
        logic [7:0] position_one;
        logic [7:0] position_two;
        logic [7:0] position_three;
        logic [7:0] position_four;
        logic [3:0] enc_switch_levels;
        logic [3:0] button_levels;
    } ebs_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/encoder_and_button_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Panel scanner for up to four rotary encoders and four buttons. Each transaction on the
// input channel is one tick sample of the pins; each sample yields exactly one result
// carrying the four wrapping 8-bit encoder positions (starting at 128) and the debounced
// active-low switch and button levels. The first sample after reset only captures the
// encoder phases, so its result shows the reset values. A sample passes an input register
// and then a result register, from which its result is offered, and one sample is taken
// every cycle while results are drained. The debounce register may only be written while
// no sample is in flight.
module encoder_and_button_scanner
    import ebs_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEFAULT,
    parameter int NUM_BUTTONS  = NUM_BUTTONS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ebs_in_t    in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output ebs_out_t        out_item,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data
);

    // Only the first four channels of each kind have pins.
    localparam int ENC_LANES = (NUM_ENCODERS < LANES) ? NUM_ENCODERS : LANES;
    localparam int BTN_LANES = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;
    localparam int SLOTS     = ENC_LANES + BTN_LANES;

    // Configuration and channel state.
    logic [7:0]      debounce_reg;
    logic            primed_reg;
    logic            primed_next;
    logic [1:0]      phase_reg    [ENC_LANES];
    logic [1:0]      phase_next   [ENC_LANES];
    logic [7:0]      position_reg [ENC_LANES];
    logic [7:0]      position_next[ENC_LANES];
    logic [SLOTS-1:0] level_reg;
    logic [SLOTS-1:0] level_next;
    logic [7:0]      count_reg    [SLOTS];
    logic [7:0]      count_next   [SLOTS];

    // Pipeline registers.
    logic            s1_valid_reg;
    ebs_in_t         s1_item_reg;
    logic            out_valid_reg;
    ebs_out_t        out_item_reg;
    ebs_out_t        out_item_next;
    logic            s1_advance;
    logic [SLOTS-1:0] raw_level;
    logic [7:0]      lane_position[LANES];
    logic [3:0]      switch_levels;
    logic [3:0]      button_levels;

    // Handshake: the input register moves on when the result register is free or drained.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    // Debounce register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write_en)
        begin
            debounce_reg <= cfg_write_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Raw switch and button levels gathered into debounce slots.
    always_comb
    begin
        for (int i = 0; i < ENC_LANES; i++)
        begin
            raw_level[i] = s1_item_reg.enc_switch_lines[i];
        end
        for (int j = 0; j < BTN_LANES; j++)
        begin
            raw_level[ENC_LANES + j] = s1_item_reg.button_lines[j];
        end
    end

    // Next channel state for the sample in the input register.
    always_comb
    begin
        primed_next = 1'b1;
        level_next  = level_reg;
        for (int i = 0; i < ENC_LANES; i++)
        begin
            phase_next[i] = {s1_item_reg.enc_a_lines[i], s1_item_reg.enc_b_lines[i]};
            if (primed_reg)
            begin
                position_next[i] = position_reg[i]
                    + STEP_TABLE[{phase_reg[i], phase_next[i]}];
            end
            else
            begin
                position_next[i] = position_reg[i];
            end
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            count_next[k] = count_reg[k];
            if (primed_reg)
            begin
                if (raw_level[k] == level_reg[k])
                begin
                    count_next[k] = '0;
                end
                else if (count_reg[k] < debounce_reg)
                begin
                    count_next[k] = count_reg[k] + 8'd1;
                end
                else
                begin
                    count_next[k] = '0;
                    level_next[k] = raw_level[k];
                end
            end
        end
    end

    // Channel state registers, updated as a sample leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            level_reg  <= '1;
            for (int i = 0; i < ENC_LANES; i++)
            begin
                phase_reg[i]    <= '0;
                position_reg[i] <= POSITION_START;
            end
            for (int k = 0; k < SLOTS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (s1_advance)
        begin
            primed_reg <= primed_next;
            level_reg  <= level_next;
            for (int i = 0; i < ENC_LANES; i++)
            begin
                phase_reg[i]    <= phase_next[i];
                position_reg[i] <= position_next[i];
            end
            for (int k = 0; k < SLOTS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

    // Lanes without an encoder read as position zero.
    for (genvar g = 0; g < LANES; g++)
    begin : gen_lane
        if (g < ENC_LANES)
        begin : gen_present
            assign lane_position[g] = position_next[g];
        end
        else
        begin : gen_absent
            assign lane_position[g] = '0;
        end
    end

    // Absent switches and buttons read as released.
    always_comb
    begin
        switch_levels = '1;
        button_levels = '1;
        for (int i = 0; i < ENC_LANES; i++)
        begin
            switch_levels[i] = level_next[i];
        end
        for (int j = 0; j < BTN_LANES; j++)
        begin
            button_levels[j] = level_next[ENC_LANES + j];
        end
    end

    always_comb
    begin
        out_item_next.position_one      = lane_position[0];
        out_item_next.position_two      = lane_position[1];
        out_item_next.position_three    = lane_position[2];
        out_item_next.position_four     = lane_position[3];
        out_item_next.enc_switch_levels = switch_levels;
        out_item_next.button_levels     = button_levels;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef SYNTHESIS
    // A sample leaving the input register always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n) s1_advance |=> out_valid)
        else $error("sample moved on but no result is held");

    // Until the first sample is through, all levels stay released.
    assert property (@(posedge clk) disable iff (!rst_n) !primed_reg |-> (level_reg == '1))
        else $error("switch level changed before the first sample");

    // Priming happens only when a transaction leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(primed_reg) |-> $past(s1_advance))
        else $error("primed without a sample");

    // Only a sample leaving the input register can start a new result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_advance))
        else $error("result appeared without a sample");
`endif

endmodule

`default_nettype wire
